### rtl/rxf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rxf_pkg: shared types and codes for the receive filter / EtherType dispatch
// Action, status, class and disposition codes, and the probe record that
// moves down the cell chain.
// ----------------------------------------------------------------------------
package rxf_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 8;

  localparam int TYPE_W = 16;
  localparam int MAC_W  = 48;
  localparam int LEN_W  = 16;
  localparam int PIDX_W = 3;

  localparam logic [LEN_W-1:0] HEADER_BYTES = 16'd14;
  localparam logic [LEN_W-1:0] MTU_RESET    = 16'd1500;

  // configuration register indexes
  localparam logic CFG_OWN_MAC = 1'b0;
  localparam logic CFG_MTU     = 1'b1;

  // actions
  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_RECEIVE  = 2'd1;
  localparam logic [1:0] ACT_TRANSMIT = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_EXISTS  = 3'd2;
  localparam logic [2:0] ST_NOSPACE = 3'd3;
  localparam logic [2:0] ST_TOOBIG  = 3'd4;

  // destination classes
  localparam logic [1:0] CL_NONE  = 2'd0;
  localparam logic [1:0] CL_HOST  = 2'd1;
  localparam logic [1:0] CL_BCAST = 2'd2;
  localparam logic [1:0] CL_MCAST = 2'd3;

  // dispositions
  localparam logic [1:0] DP_NONE    = 2'd0;
  localparam logic [1:0] DP_DELIVER = 2'd1;
  localparam logic [1:0] DP_FILTER  = 2'd2;
  localparam logic [1:0] DP_UNREG   = 2'd3;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              search;   // compare against used entries
    logic              insert;   // claim the first free entry if no match
    logic [TYPE_W-1:0] ether_type;
    logic              found;
    logic              written;
    logic [PIDX_W-1:0] pidx;
  } probe_t;

endpackage
`default_nettype wire

### rtl/rxf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rxf_cell: one EtherType table entry
// Compares the passing probe with its entry, claims itself on an insert,
// and hands the updated probe to the next cell through a register.
// ----------------------------------------------------------------------------
module rxf_cell #(
  parameter int INDEX = 0
) (
  input  wire             clk,
  input  wire             rst,
  input  rxf_pkg::probe_t probe_in,
  output rxf_pkg::probe_t probe_out
);

  logic [rxf_pkg::TYPE_W-1:0] entry;
  logic                       used;
  logic                       hit;
  logic                       take;
  rxf_pkg::probe_t            probe_next;
  rxf_pkg::probe_t            probe_q;
  logic                       probe_vld;

  assign hit  = probe_in.valid && probe_in.search && used && !probe_in.found &&
                (entry == probe_in.ether_type);
  // entries fill from the bottom, so any duplicate sits in an earlier cell
  assign take = probe_in.valid && probe_in.insert && !used && !probe_in.found &&
                !probe_in.written;

  always_comb begin
    probe_next = probe_in;
    if (hit) begin
      probe_next.found = 1'b1;
      probe_next.pidx  = rxf_pkg::PIDX_W'(INDEX);
    end
    if (take) begin
      probe_next.written = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= 1'b0;
      probe_vld <= 1'b0;
    end else begin
      probe_vld <= probe_in.valid;
      if (take) begin
        used <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_q <= probe_next;
    if (take) begin
      entry <= probe_in.ether_type;
    end
  end

  always_comb begin
    probe_out       = probe_q;
    probe_out.valid = probe_vld;
  end

endmodule
`default_nettype wire

### rtl/ethernet_rx_filter_ethertype_dispatch.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ethernet_rx_filter_ethertype_dispatch: receive filter and EtherType demux
// Registers EtherTypes into a small table, classifies received headers and
// dispatches them to a table index, and checks transmit lengths against MTU.
// ----------------------------------------------------------------------------
// One transaction at a time. A result reaches the output register after the
// search token has walked the row of table cells, one cell per cycle, with
// the first cell capturing it at the accepting edge. The token then passes
// through the result stage and on into the output register. A new input
// transaction is taken once the previous result has moved into the output
// register, so an unconsumed result in the output register holds the result
// stage and holds off the next item's walk. Every action walks the full
// row, so latency does not depend on the action.
// Configuration writes are ready whenever the block is out of reset and take
// effect on the next cycle. own_mac resets to 0 and mtu to 1500. The table
// starts empty after reset, and no input is taken while reset is high.
// ----------------------------------------------------------------------------
module ethernet_rx_filter_ethertype_dispatch #(
  parameter int TABLE_DEPTH = rxf_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire                        clk,
  input  wire                        rst,
  // configuration write channel
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire                        cfg_index,
  input  wire  [rxf_pkg::MAC_W-1:0]  cfg_data,
  // input items
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [1:0]                 action,
  input  wire  [rxf_pkg::MAC_W-1:0]  dest_mac,
  input  wire  [rxf_pkg::TYPE_W-1:0] ether_type,
  input  wire  [rxf_pkg::LEN_W-1:0]  frame_length,
  // results
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [2:0]                 status,
  output logic [1:0]                 frame_class,
  output logic [1:0]                 disposition,
  output logic [rxf_pkg::PIDX_W-1:0] protocol_index
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rxf_pkg::MAC_W-1:0] own_mac;
  logic [rxf_pkg::LEN_W-1:0] mtu;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      mtu     <= rxf_pkg::MTU_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rxf_pkg::CFG_OWN_MAC: own_mac <= cfg_data;
        rxf_pkg::CFG_MTU:     mtu     <= cfg_data[rxf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front end: decide everything that does not need the table
  // --------------------------------------------------------------------------
  logic       busy;
  logic       in_fire;
  logic       short_frame;
  logic [1:0] cls_now;
  logic [2:0] st_now;
  logic [1:0] dp_now;
  logic       lookup_now;   // receive that needs the table result
  logic       reg_now;      // register with a nonzero type

  assign in_ready = !busy && !rst;
  assign in_fire  = in_valid && in_ready;

  assign short_frame = frame_length < rxf_pkg::HEADER_BYTES;

  // address match order: own address, broadcast, group bit
  always_comb begin
    if (dest_mac == own_mac) begin
      cls_now = rxf_pkg::CL_HOST;
    end else if (&dest_mac) begin
      cls_now = rxf_pkg::CL_BCAST;
    end else if (dest_mac[40]) begin
      cls_now = rxf_pkg::CL_MCAST;
    end else begin
      cls_now = rxf_pkg::CL_NONE;
    end
  end

  always_comb begin
    st_now     = rxf_pkg::ST_OK;
    dp_now     = rxf_pkg::DP_NONE;
    lookup_now = 1'b0;
    reg_now    = 1'b0;
    case (action)
      rxf_pkg::ACT_REGISTER: begin
        if (ether_type == '0) begin
          st_now = rxf_pkg::ST_INVALID;
        end else begin
          reg_now = 1'b1;
        end
      end
      rxf_pkg::ACT_RECEIVE: begin
        if (short_frame) begin
          st_now = rxf_pkg::ST_INVALID;
        end else if (cls_now == rxf_pkg::CL_NONE) begin
          dp_now = rxf_pkg::DP_FILTER;
        end else begin
          lookup_now = 1'b1;
        end
      end
      rxf_pkg::ACT_TRANSMIT: begin
        if (frame_length > mtu) begin
          st_now = rxf_pkg::ST_TOOBIG;
        end
      end
      default: begin
        st_now = rxf_pkg::ST_INVALID;
      end
    endcase
  end

  // per-transaction context held while the token walks the chain
  logic [2:0] ctx_status;
  logic [1:0] ctx_class;
  logic [1:0] ctx_disp;
  logic       ctx_lookup;
  logic       ctx_register;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctx_status   <= st_now;
      ctx_class    <= (action == rxf_pkg::ACT_RECEIVE && !short_frame) ?
                      cls_now : rxf_pkg::CL_NONE;
      ctx_disp     <= dp_now;
      ctx_lookup   <= lookup_now;
      ctx_register <= reg_now;
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: one table entry per cell, token moves one cell per cycle
  // --------------------------------------------------------------------------
  rxf_pkg::probe_t probe [0:TABLE_DEPTH];

  always_comb begin
    probe[0].valid      = in_fire;
    probe[0].search     = lookup_now || reg_now;
    probe[0].insert     = reg_now;
    probe[0].ether_type = ether_type;
    probe[0].found      = 1'b0;
    probe[0].written    = 1'b0;
    probe[0].pidx       = '0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    rxf_cell #(
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (probe[g]),
      .probe_out (probe[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Result stage: merge the token's findings with the held context
  // --------------------------------------------------------------------------
  rxf_pkg::probe_t            tail;
  logic [2:0]                 res_status_next;
  logic [1:0]                 res_disp_next;
  logic [rxf_pkg::PIDX_W-1:0] res_pidx_next;

  assign tail = probe[TABLE_DEPTH];

  always_comb begin
    res_status_next = ctx_status;
    res_disp_next   = ctx_disp;
    res_pidx_next   = '0;
    if (ctx_register) begin
      if (tail.found) begin
        res_status_next = rxf_pkg::ST_EXISTS;
      end else if (!tail.written) begin
        res_status_next = rxf_pkg::ST_NOSPACE;
      end
    end
    if (ctx_lookup) begin
      if (tail.found) begin
        res_disp_next = rxf_pkg::DP_DELIVER;
        res_pidx_next = tail.pidx;
      end else begin
        res_disp_next = rxf_pkg::DP_UNREG;
      end
    end
  end

  logic                       res_valid;
  logic [2:0]                 res_status;
  logic [1:0]                 res_class;
  logic [1:0]                 res_disp;
  logic [rxf_pkg::PIDX_W-1:0] res_pidx;
  logic                       out_load;

  // result moves on once the output register is free or being drained
  assign out_load = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (tail.valid) begin
        res_valid <= 1'b1;
      end else if (out_load) begin
        res_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (in_fire) begin
        busy <= 1'b1;
      end else if (out_load) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      res_status <= res_status_next;
      res_class  <= ctx_class;
      res_disp   <= res_disp_next;
      res_pidx   <= res_pidx_next;
    end
    if (out_load) begin
      status         <= res_status;
      frame_class    <= res_class;
      disposition    <= res_disp;
      protocol_index <= res_pidx;
    end
  end

endmodule
`default_nettype wire
